// ===== src/c1sp_pkg.sv =====
// Package: constants, coefficient table and control type for the C1 spline evaluator.
`timescale 1ns / 1ps
package c1sp_pkg;

    localparam int DEF_X_FRAC_BITS   = 16;
    localparam int DEF_OUT_FRAC_BITS = 24;
    localparam int X_W               = 24;
    localparam int Y_W               = 32;
    localparam int N_ORD             = 4;
    localparam int N_ROW             = 5;
    localparam int N_TERM            = 10;
    localparam int TOP_J             = N_TERM - 1;
    localparam int ACC_MARGIN        = 8;

    typedef struct packed {
        logic [1:0] ord;
        logic [2:0] k;
        logic       supp;
        logic       pos;
        logic       last;
    } t_ctl;

    localparam int COEF_NUM [N_ORD][N_ROW][N_TERM] = '{
        '{
            '{0, -1, 4, 3, 0, 0, 0, 0, 0, 0},
            '{0, 0, -1, -1, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
        },
        '{
            '{0, -8, 18, 7, -12, -5, 0, 0, 0, 0},
            '{0, 2, -11, -7, 11, 5, 0, 0, 0, 0},
            '{0, 0, 2, 1, -2, -1, 0, 0, 0, 0},
            '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
        },
        '{
            '{0, -108, 192, 67, -144, -38, 24, 7, 0, 0},
            '{0, 36, -102, -68, 125, 39, -23, -7, 0, 0},
            '{0, -12, 88, 43, -110, -38, 22, 7, 0, 0},
            '{0, 0, -12, -4, 15, 5, -3, -1, 0, 0},
            '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
        },
        '{
            '{0, -2304, 3600, 1300, -2740, -557, 620, 130, -40, -9},
            '{0, 288, -576, -446, 757, 199, -194, -44, 13, 3},
            '{0, -384, 1424, 828, -1932, -567, 546, 132, -38, -9},
            '{0, 144, -1332, -520, 1813, 497, -518, -130, 37, 9},
            '{0, 0, 144, 36, -196, -49, 56, 14, -4, -1}
        }
    };

    localparam int COEF_DEN [N_ORD][N_ROW] = '{
        '{2, 2, 1, 1, 1},
        '{12, 24, 24, 1, 1},
        '{144, 240, 720, 720, 1},
        '{2880, 1440, 10080, 40320, 40320}
    };

    // coefficient in Q.frac, rounded half away from zero
    function automatic longint coef_fix(int ord, int row, int j, int frac);
        longint n;
        longint a;
        longint x;
        longint q;
        n = longint'(COEF_NUM[ord][row][j]);
        a = (n < 0) ? -n : n;
        x = a << (frac + 1);
        case (COEF_DEN[ord][row])
            1:       q = (x + 1) / 2;
            2:       q = (x + 2) / 4;
            12:      q = (x + 12) / 24;
            24:      q = (x + 24) / 48;
            144:     q = (x + 144) / 288;
            240:     q = (x + 240) / 480;
            720:     q = (x + 720) / 1440;
            1440:    q = (x + 1440) / 2880;
            2880:    q = (x + 2880) / 5760;
            10080:   q = (x + 10080) / 20160;
            40320:   q = (x + 40320) / 80640;
            default: q = 0;
        endcase
        return (n < 0) ? -q : q;
    endfunction

endpackage

// ===== src/c1sp_if.sv =====
// Interfaces: sample input, result output and configuration write channels.
`timescale 1ns / 1ps
interface c1sp_in_if;
    logic        valid;
    logic        ready;
    logic signed [23:0] x_pos;
    logic        last_in;
    modport source (output valid, output x_pos, output last_in, input ready);
    modport sink (input valid, input x_pos, input last_in, output ready);
endinterface

interface c1sp_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] value_out;
    logic signed [31:0] slope_out;
    logic        inside_support;
    logic        last_out;
    modport source (output valid, output value_out, output slope_out,
                    output inside_support, output last_out, input ready);
    modport sink (input valid, input value_out, input slope_out,
                  input inside_support, input last_out, output ready);
endinterface

interface c1sp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] order_code;
    modport source (output valid, output order_code, input ready);
    modport sink (input valid, input order_code, output ready);
endinterface

// ===== src/c1_spline_value_and_slope.sv =====
// Top level: C1 spline value and slope evaluator, entry stage, cell chain, output register.
//
//  channel  | dir | beat fields
//  i_cfg    | in  | order_code
//  i_in     | in  | x_pos, last_in
//  o_out    | out | value_out, slope_out, inside_support, last_out
//
//  One beat per cycle sustained while o_out is ready; stages: entry, nine Horner cells, output.
//  The chain of nine cells, one per Horner step of the nonic, sets the latency.
//  Each stage holds its beat while the next one is full and stalled; bubbles collapse.
//  Synchronous active-low reset clears valid bits and sets order_code to cubic.
`timescale 1ns / 1ps
module c1_spline_value_and_slope #(
    parameter int X_FRAC_BITS   = c1sp_pkg::DEF_X_FRAC_BITS,
    parameter int OUT_FRAC_BITS = c1sp_pkg::DEF_OUT_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    c1sp_cfg_if.sink    i_cfg,
    c1sp_in_if.sink     i_in,
    c1sp_out_if.source  o_out
);
    import c1sp_pkg::*;

    localparam int ACC_W = OUT_FRAC_BITS + ACC_MARGIN;
    localparam int IP_W  = X_W + 1 - X_FRAC_BITS;
    localparam longint Y_MAX = (longint'(1) <<< (Y_W - 1)) - 1;
    localparam longint Y_MIN = -(longint'(1) <<< (Y_W - 1));

    logic [1:0] r_ord;

    logic signed [X_W:0]          xs;
    logic [X_W:0]                 mag;
    logic [IP_W-1:0]              ip;
    t_ctl                         n_ctl;
    logic signed [X_FRAC_BITS:0]  n_t;
    logic signed [ACC_W-1:0]      w_c9  [N_ORD][N_ROW];
    logic signed [ACC_W-1:0]      w_dc9 [N_ORD][N_ROW];
    logic signed [ACC_W-1:0]      n_f;
    logic signed [ACC_W-1:0]      n_df;

    logic                         w_vld [TOP_J+1];
    logic                         w_rdy [TOP_J+1];
    logic signed [ACC_W-1:0]      w_f   [TOP_J+1];
    logic signed [ACC_W-1:0]      w_df  [TOP_J+1];
    logic signed [X_FRAC_BITS:0]  w_t   [TOP_J+1];
    t_ctl                         w_ctl [TOP_J+1];

    logic                         r_e_valid;
    logic signed [ACC_W-1:0]      r_e_f;
    logic signed [ACC_W-1:0]      r_e_df;
    logic signed [X_FRAC_BITS:0]  r_e_t;
    t_ctl                         r_e_ctl;

    logic                         out_up_ready;
    logic signed [ACC_W:0]        sd;
    logic signed [63:0]           vf;
    logic signed [63:0]           vd;
    logic signed [Y_W-1:0]        n_val;
    logic signed [Y_W-1:0]        n_slp;

    logic                         r_o_valid;
    logic signed [Y_W-1:0]        r_val;
    logic signed [Y_W-1:0]        r_slp;
    logic                         r_ins;
    logic                         r_last;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ord <= '0;
        end else if (i_cfg.valid) begin
            r_ord <= i_cfg.order_code;
        end
    end

    for (genvar go = 0; go < N_ORD; go++) begin : g_ord
        for (genvar gr = 0; gr < N_ROW; gr++) begin : g_row
            assign w_c9[go][gr]  = ACC_W'(coef_fix(go, gr, TOP_J, OUT_FRAC_BITS));
            assign w_dc9[go][gr] =
                ACC_W'(longint'(TOP_J) * coef_fix(go, gr, TOP_J, OUT_FRAC_BITS));
        end
    end

    always_comb begin
        xs           = {i_in.x_pos[X_W-1], i_in.x_pos};
        mag          = xs[X_W] ? (X_W+1)'(-xs) : xs;
        ip           = mag[X_W:X_FRAC_BITS];
        n_ctl.ord    = r_ord;
        n_ctl.k      = 3'(ip);
        n_ctl.supp   = 32'(ip) < (32'(r_ord) + 32'd2);
        n_ctl.pos    = !xs[X_W] && (xs != '0);
        n_ctl.last   = i_in.last_in;
        n_t          = {1'b1, mag[X_FRAC_BITS-1:0]};
        n_f          = '0;
        n_df         = '0;
        if (n_ctl.k < 3'(N_ROW)) begin
            n_f  = w_c9[r_ord][n_ctl.k];
            n_df = w_dc9[r_ord][n_ctl.k];
        end
    end

    assign i_in.ready = !r_e_valid || w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_e_valid <= i_in.valid;
        end
        if (i_in.ready) begin
            r_e_f   <= n_f;
            r_e_df  <= n_df;
            r_e_t   <= n_t;
            r_e_ctl <= n_ctl;
        end
    end

    assign w_vld[0] = r_e_valid;
    assign w_f[0]   = r_e_f;
    assign w_df[0]  = r_e_df;
    assign w_t[0]   = r_e_t;
    assign w_ctl[0] = r_e_ctl;
    assign w_rdy[TOP_J] = out_up_ready;

    for (genvar gi = 0; gi < TOP_J; gi++) begin : g_cell
        c1sp_cell #(
            .X_FRAC_BITS   (X_FRAC_BITS),
            .OUT_FRAC_BITS (OUT_FRAC_BITS),
            .J             (TOP_J - 1 - gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[gi]),
            .o_ready (w_rdy[gi]),
            .i_f     (w_f[gi]),
            .i_df    (w_df[gi]),
            .i_t     (w_t[gi]),
            .i_ctl   (w_ctl[gi]),
            .o_valid (w_vld[gi+1]),
            .i_ready (w_rdy[gi+1]),
            .o_f     (w_f[gi+1]),
            .o_df    (w_df[gi+1]),
            .o_t     (w_t[gi+1]),
            .o_ctl   (w_ctl[gi+1])
        );
    end

    always_comb begin
        sd = w_ctl[TOP_J].pos ? (ACC_W+1)'(w_df[TOP_J]) : -(ACC_W+1)'(w_df[TOP_J]);
        vf = 64'(w_f[TOP_J]);
        vd = 64'(sd);
        if (!w_ctl[TOP_J].supp) begin
            vf = '0;
            vd = '0;
        end
        if (vf > Y_MAX) begin
            n_val = Y_W'(Y_MAX);
        end else if (vf < Y_MIN) begin
            n_val = Y_W'(Y_MIN);
        end else begin
            n_val = Y_W'(vf);
        end
        if (vd > Y_MAX) begin
            n_slp = Y_W'(Y_MAX);
        end else if (vd < Y_MIN) begin
            n_slp = Y_W'(Y_MIN);
        end else begin
            n_slp = Y_W'(vd);
        end
    end

    assign out_up_ready = !r_o_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_up_ready) begin
            r_o_valid <= w_vld[TOP_J];
        end
        if (out_up_ready) begin
            r_val  <= n_val;
            r_slp  <= n_slp;
            r_ins  <= w_ctl[TOP_J].supp;
            r_last <= w_ctl[TOP_J].last;
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.value_out      = r_val;
    assign o_out.slope_out      = r_slp;
    assign o_out.inside_support = r_ins;
    assign o_out.last_out       = r_last;

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_ins) |-> (r_val == '0 && r_slp == '0))
        else $error("outside beat carries nonzero result");

    a_entry_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_valid && !w_rdy[0]) |=> (r_e_valid && $stable(r_e_f) && $stable(r_e_ctl)))
        else $error("entry stage dropped a stalled beat");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_o_valid && !r_e_valid))
        else $error("pipeline not empty after reset");

endmodule

// ===== src/c1sp_cell.sv =====
// Horner cell: one multiply-round-add step of the value and slope chains; the J = 0 cell passes slope through.
`timescale 1ns / 1ps
module c1sp_cell #(
    parameter int X_FRAC_BITS   = c1sp_pkg::DEF_X_FRAC_BITS,
    parameter int OUT_FRAC_BITS = c1sp_pkg::DEF_OUT_FRAC_BITS,
    parameter int J             = 0
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_valid,
    output logic                                                  o_ready,
    input  logic signed [OUT_FRAC_BITS+c1sp_pkg::ACC_MARGIN-1:0]  i_f,
    input  logic signed [OUT_FRAC_BITS+c1sp_pkg::ACC_MARGIN-1:0]  i_df,
    input  logic signed [X_FRAC_BITS:0]                           i_t,
    input  c1sp_pkg::t_ctl                                        i_ctl,
    output logic                                                  o_valid,
    input  logic                                                  i_ready,
    output logic signed [OUT_FRAC_BITS+c1sp_pkg::ACC_MARGIN-1:0]  o_f,
    output logic signed [OUT_FRAC_BITS+c1sp_pkg::ACC_MARGIN-1:0]  o_df,
    output logic signed [X_FRAC_BITS:0]                           o_t,
    output c1sp_pkg::t_ctl                                        o_ctl
);
    import c1sp_pkg::*;

    localparam int ACC_W = OUT_FRAC_BITS + ACC_MARGIN;
    localparam int PW    = ACC_W + X_FRAC_BITS + 1;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (X_FRAC_BITS - 1);

    logic signed [ACC_W-1:0] w_c  [N_ORD][N_ROW];
    logic signed [ACC_W-1:0] w_jc [N_ORD][N_ROW];
    logic signed [ACC_W-1:0] c;
    logic signed [ACC_W-1:0] jc;
    logic signed [PW-1:0]    pf;
    logic signed [PW-1:0]    pdf;
    logic signed [PW-1:0]    sf;
    logic signed [PW-1:0]    sdf;
    logic signed [ACC_W-1:0] n_f;
    logic signed [ACC_W-1:0] n_df;

    logic                    r_valid;
    logic signed [ACC_W-1:0] r_f;
    logic signed [ACC_W-1:0] r_df;
    logic signed [X_FRAC_BITS:0] r_t;
    t_ctl                    r_ctl;

    for (genvar go = 0; go < N_ORD; go++) begin : g_ord
        for (genvar gr = 0; gr < N_ROW; gr++) begin : g_row
            assign w_c[go][gr]  = ACC_W'(coef_fix(go, gr, J, OUT_FRAC_BITS));
            assign w_jc[go][gr] = ACC_W'(longint'(J) * coef_fix(go, gr, J, OUT_FRAC_BITS));
        end
    end

    always_comb begin
        c  = '0;
        jc = '0;
        if (i_ctl.k < 3'(N_ROW)) begin
            c  = w_c[i_ctl.ord][i_ctl.k];
            jc = w_jc[i_ctl.ord][i_ctl.k];
        end
        pf   = i_f * i_t;
        pdf  = i_df * i_t;
        sf   = (pf + HALF) >>> X_FRAC_BITS;
        sdf  = (pdf + HALF) >>> X_FRAC_BITS;
        n_f  = ACC_W'(sf) + c;
        n_df = (J == 0) ? i_df : ACC_W'(sdf) + jc;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready) begin
            r_f   <= n_f;
            r_df  <= n_df;
            r_t   <= i_t;
            r_ctl <= i_ctl;
        end
    end

    assign o_valid = r_valid;
    assign o_f     = r_f;
    assign o_df    = r_df;
    assign o_t     = r_t;
    assign o_ctl   = r_ctl;

endmodule
